// ----- rtl/fsf_pkg.sv -----
package fsf_pkg;

  localparam int POS_W    = 20;
  localparam int D2_W     = 2 * POS_W + 1;
  localparam int MD2_W    = 2 * POS_W;
  localparam int SUM_W    = 48;
  localparam int MAG_W    = SUM_W - 1;
  localparam int SHIFT    = 32;
  localparam int TERM_W   = SHIFT + 1;
  localparam int WEIGHT_W = 16;
  localparam int FORCE_W  = 18;
  localparam int NORM_W   = 30;
  localparam int SQ_W     = 2 * NORM_W + 1;
  localparam int ROOT_W   = NORM_W + 1;
  localparam int DIV_RW   = D2_W + 1;
  localparam int CFG_W    = 20;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_RULE_ENABLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RULE_WEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISTANCE = 2'd2;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 16'd4096;
  localparam logic [POS_W-1:0]    MIN_DIST_RST = 20'd5120;

  localparam logic signed [SUM_W:0] SUM_MAX = 49'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [SUM_W:0] SUM_MIN = -SUM_MAX;

  typedef struct packed {
    logic [POS_W-1:0] ax;
    logic [POS_W-1:0] ay;
    logic             neg_x;
    logic             neg_y;
    logic [D2_W-1:0]  d2;
    logic             use_nbr;
    logic             last;
  } fsf_entry_t;

endpackage

// ----- rtl/fsf_if.sv -----
interface fsf_in_if;
  import fsf_pkg::*;
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] self_x;
  logic [POS_W-1:0] self_y;
  logic [POS_W-1:0] nbr_x;
  logic [POS_W-1:0] nbr_y;
  logic             nbr_valid;
  logic             last;
  modport source(output valid, self_x, self_y, nbr_x, nbr_y, nbr_valid, last, input ready);
  modport sink(input valid, self_x, self_y, nbr_x, nbr_y, nbr_valid, last, output ready);
endinterface

interface fsf_out_if;
  import fsf_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [FORCE_W-1:0] force_x;
  logic signed [FORCE_W-1:0] force_y;
  modport source(output valid, force_x, force_y, input ready);
  modport sink(input valid, force_x, force_y, output ready);
endinterface

// ----- rtl/fsf_front.sv -----
module fsf_front (
  input  logic                      clk,
  input  logic                      rst_n,
  fsf_in_if.sink                    in_ch,
  input  logic [fsf_pkg::POS_W-1:0] min_distance,
  input  logic                      q_full,
  output logic                      q_push,
  output fsf_pkg::fsf_entry_t       q_entry
);
  import fsf_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_SQ   = 3'b010,
    F_CHK  = 3'b100
  } fstate_t;

  fstate_t            state_r, state_nxt;
  logic [POS_W-1:0]   ax_r, ay_r;
  logic               neg_x_r, neg_y_r, nv_r, last_r;
  logic [MD2_W-1:0]   sqx_r, sqy_r, md2_r;
  logic [D2_W-1:0]    d2;

  assign in_ch.ready = (state_r == F_IDLE);
  assign d2 = {1'b0, sqx_r} + {1'b0, sqy_r};

  always_comb begin
    q_entry.ax      = ax_r;
    q_entry.ay      = ay_r;
    q_entry.neg_x   = neg_x_r;
    q_entry.neg_y   = neg_y_r;
    q_entry.d2      = d2;
    q_entry.use_nbr = nv_r && (d2 != '0) && (d2 < {1'b0, md2_r});
    q_entry.last    = last_r;
    q_push          = (state_r == F_CHK) && !q_full;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: if (in_ch.valid) state_nxt = F_SQ;
      F_SQ:   state_nxt = F_CHK;
      F_CHK:  if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && in_ch.valid) begin
      neg_x_r <= in_ch.self_x < in_ch.nbr_x;
      neg_y_r <= in_ch.self_y < in_ch.nbr_y;
      ax_r    <= (in_ch.self_x < in_ch.nbr_x) ? in_ch.nbr_x - in_ch.self_x
                                              : in_ch.self_x - in_ch.nbr_x;
      ay_r    <= (in_ch.self_y < in_ch.nbr_y) ? in_ch.nbr_y - in_ch.self_y
                                              : in_ch.self_y - in_ch.nbr_y;
      nv_r    <= in_ch.nbr_valid;
      last_r  <= in_ch.last;
    end
    if (state_r == F_SQ) begin
      sqx_r <= ax_r * ax_r;
      sqy_r <= ay_r * ay_r;
      md2_r <= min_distance * min_distance;
    end
  end
endmodule

// ----- rtl/fsf_fifo.sv -----
module fsf_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  fsf_pkg::fsf_entry_t wr_entry,
  input  logic                pop,
  output fsf_pkg::fsf_entry_t rd_entry,
  output logic                full,
  output logic                empty
);
  import fsf_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  fsf_entry_t     mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  cnt_r;
  logic           do_push, do_pop;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign rd_entry = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wr_entry;
  end
endmodule

// ----- rtl/fsf_div.sv -----
module fsf_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [fsf_pkg::DIV_RW-2:0]  rem_init,
  input  logic [fsf_pkg::TERM_W-1:0]  num_low,
  input  logic [fsf_pkg::D2_W-1:0]    divisor,
  output logic                        busy,
  output logic [fsf_pkg::TERM_W-1:0]  quot
);
  import fsf_pkg::*;

  localparam int CNT_W = $clog2(TERM_W + 1);

  logic [DIV_RW-1:0] rem_r;
  logic [TERM_W-1:0] low_r, quot_r;
  logic [D2_W-1:0]   div_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DIV_RW-1:0] trial;
  logic              ge;

  assign busy  = (cnt_r != '0);
  assign quot  = quot_r;
  assign trial = {rem_r[DIV_RW-2:0], low_r[TERM_W-1]};
  assign ge    = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_W'(TERM_W);
    end else if (busy) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= {1'b0, rem_init};
      low_r  <= num_low;
      div_r  <= divisor;
      quot_r <= '0;
    end else if (busy) begin
      rem_r  <= ge ? trial - {1'b0, div_r} : trial;
      low_r  <= {low_r[TERM_W-2:0], 1'b0};
      quot_r <= {quot_r[TERM_W-2:0], ge};
    end
  end
endmodule

// ----- rtl/fsf_back.sv -----
module fsf_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  fsf_pkg::fsf_entry_t          q_entry,
  output logic                         q_pop,
  input  logic                         rule_enable,
  input  logic [fsf_pkg::WEIGHT_W-1:0] rule_weight,
  fsf_out_if.source                    out_ch
);
  import fsf_pkg::*;

  typedef enum logic [8:0] {
    B_IDLE = 9'b000000001,
    B_DIV  = 9'b000000010,
    B_ACC  = 9'b000000100,
    B_FIN  = 9'b000001000,
    B_NORM = 9'b000010000,
    B_SQ   = 9'b000100000,
    B_ROOT = 9'b001000000,
    B_MUL  = 9'b010000000,
    B_FDIV = 9'b100000000
  } bstate_t;

  localparam int FN_W = WEIGHT_W + NORM_W;

  bstate_t                   state_r, state_nxt;
  logic                      out_pend_r;
  logic signed [SUM_W-1:0]   sum_x_r, sum_y_r;
  logic                      neg_x_r, neg_y_r, last_r;
  logic                      fneg_x_r, fneg_y_r;
  logic [MAG_W-1:0]          ux_r, uy_r;
  logic [SQ_W-1:0]           sqx_r, sqy_r;
  logic [SQ_W-1:0]           v_r, res_r, bit_r;
  logic [FN_W-1:0]           nx, ny;
  logic signed [FORCE_W-1:0] fx_r, fy_r;
  logic                      out_valid_r;
  logic signed [FORCE_W-1:0] out_x_r, out_y_r;

  logic                      div_start;
  logic [DIV_RW-2:0]         rx_init, ry_init;
  logic [TERM_W-1:0]         lx, ly;
  logic [D2_W-1:0]           dv;
  logic                      bx, by;
  logic [TERM_W-1:0]         qx, qy;
  logic [MAG_W-1:0]          m;
  logic [SQ_W-1:0]           rt_tmp;
  logic signed [SUM_W:0]     ax_sum, ay_sum;
  logic                      out_free;

  fsf_div u_div_x (.clk, .rst_n, .start(div_start), .rem_init(rx_init), .num_low(lx),
                   .divisor(dv), .busy(bx), .quot(qx));
  fsf_div u_div_y (.clk, .rst_n, .start(div_start), .rem_init(ry_init), .num_low(ly),
                   .divisor(dv), .busy(by), .quot(qy));

  assign out_free = !out_valid_r || out_ch.ready;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.force_x = out_x_r;
  assign out_ch.force_y = out_y_r;
  assign q_pop  = (state_r == B_IDLE) && !q_empty && !out_pend_r;
  assign m      = (ux_r > uy_r) ? ux_r : uy_r;
  assign rt_tmp = res_r + bit_r;
  assign nx     = rule_weight * ux_r[NORM_W-1:0];
  assign ny     = rule_weight * uy_r[NORM_W-1:0];

  always_comb begin
    ax_sum = {sum_x_r[SUM_W-1], sum_x_r};
    ay_sum = {sum_y_r[SUM_W-1], sum_y_r};
    if (neg_x_r) ax_sum = ax_sum - (SUM_W+1)'(qx);
    else         ax_sum = ax_sum + (SUM_W+1)'(qx);
    if (neg_y_r) ay_sum = ay_sum - (SUM_W+1)'(qy);
    else         ay_sum = ay_sum + (SUM_W+1)'(qy);
    if (ax_sum > SUM_MAX) ax_sum = SUM_MAX;
    if (ax_sum < SUM_MIN) ax_sum = SUM_MIN;
    if (ay_sum > SUM_MAX) ay_sum = SUM_MAX;
    if (ay_sum < SUM_MIN) ay_sum = SUM_MIN;
  end

  always_comb begin
    div_start = 1'b0;
    rx_init   = (DIV_RW-1)'(q_entry.ax >> 1);
    ry_init   = (DIV_RW-1)'(q_entry.ay >> 1);
    lx        = {q_entry.ax[0], {SHIFT{1'b0}}};
    ly        = {q_entry.ay[0], {SHIFT{1'b0}}};
    dv        = q_entry.d2;
    if (state_r == B_MUL) begin
      rx_init = (DIV_RW-1)'(nx >> TERM_W);
      ry_init = (DIV_RW-1)'(ny >> TERM_W);
      lx      = nx[TERM_W-1:0];
      ly      = ny[TERM_W-1:0];
      dv      = D2_W'(res_r[ROOT_W-1:0]);
      div_start = 1'b1;
    end else if (q_pop && q_entry.use_nbr) begin
      div_start = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: if (q_pop) state_nxt = q_entry.use_nbr ? B_DIV : (q_entry.last ? B_FIN : B_IDLE);
      B_DIV:  if (!bx && !by) state_nxt = B_ACC;
      B_ACC:  state_nxt = last_r ? B_FIN : B_IDLE;
      B_FIN:  state_nxt = (rule_enable && (sum_x_r != '0 || sum_y_r != '0)) ? B_NORM : B_IDLE;
      B_NORM: if (m[NORM_W-1:NORM_W-1] != '0 && m[MAG_W-1:NORM_W] == '0) state_nxt = B_SQ;
      B_SQ:   state_nxt = B_ROOT;
      B_ROOT: if (bit_r == '0 && (res_r != '0 || v_r != '0)) state_nxt = B_MUL;
      B_MUL:  state_nxt = B_FDIV;
      B_FDIV: if (!bx && !by) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      out_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_ACC) begin
        sum_x_r <= SUM_W'(ax_sum);
        sum_y_r <= SUM_W'(ay_sum);
      end
      if (state_r == B_FIN) begin
        sum_x_r <= '0;
        sum_y_r <= '0;
      end
      // raise a pending result when the force is final, hand it over when the slot frees
      if ((state_r == B_FIN && state_nxt == B_IDLE) ||
          (state_r == B_FDIV && !bx && !by)) begin
        out_pend_r <= 1'b1;
      end else if (out_pend_r && out_free) begin
        out_pend_r <= 1'b0;
      end
      if (out_pend_r && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready)      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      neg_x_r <= q_entry.neg_x;
      neg_y_r <= q_entry.neg_y;
      last_r  <= q_entry.last;
    end
    if (state_r == B_FIN) begin
      fneg_x_r <= sum_x_r[SUM_W-1];
      fneg_y_r <= sum_y_r[SUM_W-1];
      ux_r <= sum_x_r[SUM_W-1] ? MAG_W'(-sum_x_r) : MAG_W'(sum_x_r);
      uy_r <= sum_y_r[SUM_W-1] ? MAG_W'(-sum_y_r) : MAG_W'(sum_y_r);
      fx_r <= '0;
      fy_r <= '0;
    end
    if (state_r == B_NORM) begin
      if (m[MAG_W-1:NORM_W] != '0) begin
        ux_r <= ux_r >> 1;
        uy_r <= uy_r >> 1;
      end else if (!m[NORM_W-1]) begin
        ux_r <= ux_r << 1;
        uy_r <= uy_r << 1;
      end
    end
    if (state_r == B_SQ) begin
      sqx_r <= SQ_W'(ux_r[NORM_W-1:0] * ux_r[NORM_W-1:0]);
      sqy_r <= SQ_W'(uy_r[NORM_W-1:0] * uy_r[NORM_W-1:0]);
      v_r   <= '0;
      res_r <= '0;
      bit_r <= '0;
    end
    if (state_r == B_ROOT) begin
      if (bit_r == '0 && res_r == '0 && v_r == '0) begin
        v_r   <= sqx_r + sqy_r;
        bit_r <= SQ_W'(1) << (SQ_W - 1);
      end else if (bit_r != '0) begin
        if (v_r >= rt_tmp) begin
          v_r   <= v_r - rt_tmp;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
    end
    if (state_r == B_FDIV && !bx && !by) begin
      fx_r <= fneg_x_r ? -FORCE_W'(qx[WEIGHT_W-1:0]) : FORCE_W'(qx[WEIGHT_W-1:0]);
      fy_r <= fneg_y_r ? -FORCE_W'(qy[WEIGHT_W-1:0]) : FORCE_W'(qy[WEIGHT_W-1:0]);
    end
    if (out_pend_r && out_free) begin
      out_x_r <= fx_r;
      out_y_r <= fy_r;
    end
  end
endmodule

// ----- rtl/flock_separation_force.sv -----
// Separation force of one particle from a stream of its neighbours.
// Steps: the front takes the item, squares the offsets and pushes the classified entry;
// the back pops a counted neighbour, divides and accumulates, and only pops a skipped one;
// the last item adds a finish, then for a nonzero sum with the rule enabled normalize, square,
// root, multiply, divide, handoff. The back pops no new item during its 33-step divide.
// Reset (synchronous, rst_n low): sums cleared, queue empty, config to defaults.
module flock_separation_force #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  fsf_in_if.sink                        in_ch,
  fsf_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [fsf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fsf_pkg::CFG_W-1:0]     cfg_data
);
  import fsf_pkg::*;

  // configuration registers
  logic                rule_enable_r;
  logic [WEIGHT_W-1:0] rule_weight_r;
  logic [POS_W-1:0]    min_distance_r;

  // queue between front and back
  fsf_entry_t push_entry, pop_entry;
  logic       q_push, q_pop, q_full, q_empty;

  // decode writes; an index past the list is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_enable_r  <= 1'b1;
      rule_weight_r  <= WEIGHT_RST;
      min_distance_r <= MIN_DIST_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RULE_ENABLE:  rule_enable_r  <= cfg_data[0];
        CFG_RULE_WEIGHT:  rule_weight_r  <= cfg_data[WEIGHT_W-1:0];
        CFG_MIN_DISTANCE: min_distance_r <= cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // front: take the item, square the offsets, classify against the threshold
  fsf_front u_front (
    .clk, .rst_n, .in_ch,
    .min_distance(min_distance_r),
    .q_full, .q_push, .q_entry(push_entry)
  );

  fsf_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk, .rst_n,
    .push(q_push), .wr_entry(push_entry),
    .pop(q_pop), .rd_entry(pop_entry),
    .full(q_full), .empty(q_empty)
  );

  // back: accumulate reciprocal terms, normalize and weight on the last item
  fsf_back u_back (
    .clk, .rst_n,
    .q_empty, .q_entry(pop_entry), .q_pop,
    .rule_enable(rule_enable_r), .rule_weight(rule_weight_r),
    .out_ch
  );
endmodule
